// ----- src/erq_pkg.sv -----
// Package for the exit request queue: sizes, operation codes, state encoding,
// the result and status structs, and the ring address helper.
// Used by erq_ctrl and exit_request_queue; depends on nothing else.
`default_nettype none

package erq_pkg;

    // Queue size and derived widths.
    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;

    // Field widths.
    localparam int ENTRY_W = 8;
    localparam int NIB_W   = 4;
    localparam int KIND_W  = 3;

    // Destination mask sits in the upper nibble, source number in the lower.
    localparam logic [ENTRY_W-1:0] DEST_MASK = 8'hF0;
    localparam logic [ENTRY_W-1:0] SRC_MASK  = 8'h0F;

    typedef logic [PTR_W-1:0]   t_ptr;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [ENTRY_W-1:0] t_entry;
    typedef logic [NIB_W-1:0]   t_nib;

    // Operation codes carried in the input tuser.
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH  = 3'd0,
        KIND_POP   = 3'd1,
        KIND_QUERY = 3'd2,
        KIND_SHOW  = 3'd3,
        KIND_CLEAR = 3'd4
    } t_erq_kind;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_erq_state;

    // One result transaction.
    typedef struct packed {
        logic   accepted;
        t_entry popped;
        logic   is_queued;
        logic   not_empty;
        t_entry display_bits;
    } t_erq_result;

    // Status from the sequencer to the top level.
    typedef struct packed {
        logic busy;
        t_cnt count;
    } t_erq_status;

    // Ring address of the entry that lies off places behind base.
    function automatic t_ptr erq_wrap(t_ptr base, t_cnt off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(off);
        if (s >= SUM_W'(QUEUE_DEPTH)) begin
            s = s - SUM_W'(QUEUE_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/erq_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the queued request bytes; no dependencies.
`default_nettype none

module erq_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- src/erq_ctrl.sv -----
// Sequencer of the exit request queue: ring pointers, active request, display
// register and the scan over the request RAM. Depends on erq_pkg and erq_ram.
`default_nettype none

module erq_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [2:0]           i_kind,
    input  wire erq_pkg::t_entry      i_entry,
    input  wire erq_pkg::t_nib        i_source,
    output logic                      o_res_valid,
    input  wire logic                 i_res_ready,
    output erq_pkg::t_erq_result      o_res,
    output erq_pkg::t_erq_status      o_status
);

    // Control state.
    erq_pkg::t_erq_state r_state, n_state;
    erq_pkg::t_ptr       r_head, n_head;
    erq_pkg::t_cnt       r_count, n_count;
    erq_pkg::t_cnt       r_idx, n_idx;
    logic                r_rd_vld, n_rd_vld;
    erq_pkg::t_entry     r_active, n_active;
    erq_pkg::t_entry     r_display, n_display;

    // Transaction being worked on, scan accumulators and the result.
    logic [2:0]           r_kind, n_kind;
    erq_pkg::t_entry      r_entry, n_entry;
    erq_pkg::t_nib        r_source, n_source;
    logic                 r_hit, n_hit;
    erq_pkg::t_nib        r_dest, n_dest;
    erq_pkg::t_entry      r_pop, n_pop;
    erq_pkg::t_erq_result r_res, n_res;

    // RAM ports.
    logic            w_rd_en;
    erq_pkg::t_ptr   w_rd_addr;
    erq_pkg::t_entry w_rd_data;
    logic            w_wr_en;
    erq_pkg::t_ptr   w_wr_addr;

    erq_pkg::t_cnt w_limit;
    logic          w_scan_end;
    logic          w_accept;

    erq_ram #(
        .DEPTH(erq_pkg::QUEUE_DEPTH),
        .WIDTH(erq_pkg::ENTRY_W)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(r_entry),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    assign w_accept = (r_state == erq_pkg::ST_IDLE) && i_in_valid;

    // Number of entries the operation reads: the head for a pop of a non-empty
    // queue, all for a query or a show, none otherwise.
    always_comb begin
        if (r_kind == erq_pkg::KIND_POP) begin
            w_limit = (r_count != '0) ? erq_pkg::t_cnt'(1) : '0;
        end else if ((r_kind == erq_pkg::KIND_QUERY) || (r_kind == erq_pkg::KIND_SHOW)) begin
            w_limit = r_count;
        end else begin
            w_limit = '0;
        end
    end

    // The scan ends once every read has been issued and its data consumed.
    assign w_scan_end = (r_idx == w_limit) && !r_rd_vld;

    // Read addresses walk the ring from the head; pushes write behind the tail.
    assign w_rd_en   = (r_state == erq_pkg::ST_SCAN) && (r_idx != w_limit);
    assign w_rd_addr = erq_pkg::erq_wrap(r_head, r_idx);
    assign w_wr_addr = erq_pkg::erq_wrap(r_head, r_count);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            erq_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = erq_pkg::ST_SCAN;
                end
            end
            erq_pkg::ST_SCAN: begin
                if (w_scan_end) begin
                    n_state = erq_pkg::ST_DONE;
                end
            end
            erq_pkg::ST_DONE: begin
                if (i_res_ready) begin
                    n_state = erq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = erq_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake outputs.
    always_comb begin
        o_in_ready  = (r_state == erq_pkg::ST_IDLE);
        o_res_valid = (r_state == erq_pkg::ST_DONE);
        o_res       = r_res;
        o_status    = '{busy: (r_state != erq_pkg::ST_IDLE), count: r_count};
    end

    // Datapath: latch the transaction, accumulate the scan, commit at its end.
    // Only one transaction is in flight, so a RAM write never meets a read of
    // the same entry.
    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_idx     = r_idx;
        n_rd_vld  = 1'b0;
        n_active  = r_active;
        n_display = r_display;
        n_kind    = r_kind;
        n_entry   = r_entry;
        n_source  = r_source;
        n_hit     = r_hit;
        n_dest    = r_dest;
        n_pop     = r_pop;
        n_res     = r_res;
        w_wr_en   = 1'b0;

        if (w_accept) begin
            n_kind   = i_kind;
            n_entry  = i_entry;
            n_source = i_source;
            n_idx    = '0;
            n_hit    = 1'b0;
            n_dest   = '0;
            n_pop    = '0;
        end

        if (r_state == erq_pkg::ST_SCAN) begin
            if (w_rd_en) begin
                n_idx = r_idx + erq_pkg::t_cnt'(1);
            end
            n_rd_vld = w_rd_en;

            // Fold in the entry read on the previous cycle.
            if (r_rd_vld) begin
                n_hit  = r_hit | ((w_rd_data & erq_pkg::SRC_MASK) == {4'h0, r_source});
                n_dest = r_dest | w_rd_data[7:4];
                n_pop  = w_rd_data;
            end

            if (w_scan_end) begin
                n_res = '0;
                case (r_kind)
                    erq_pkg::KIND_PUSH: begin
                        if (r_entry == '0) begin
                            // A zero entry purges everything.
                            n_head       = '0;
                            n_count      = '0;
                            n_active     = '0;
                            n_display    = '0;
                            n_res.accepted = 1'b1;
                        end else if (r_count != erq_pkg::t_cnt'(erq_pkg::QUEUE_DEPTH)) begin
                            w_wr_en        = 1'b1;
                            n_count        = r_count + erq_pkg::t_cnt'(1);
                            n_res.accepted = 1'b1;
                        end
                    end
                    erq_pkg::KIND_POP: begin
                        if (r_count != '0) begin
                            n_head  = erq_pkg::erq_wrap(r_head, erq_pkg::t_cnt'(1));
                            n_count = r_count - erq_pkg::t_cnt'(1);
                        end
                        n_active     = r_pop;
                        n_res.popped = r_pop;
                    end
                    erq_pkg::KIND_QUERY: begin
                        n_res.is_queued = r_hit ||
                            ((r_active != '0) &&
                             ((r_active & erq_pkg::SRC_MASK) == {4'h0, r_source}));
                    end
                    erq_pkg::KIND_SHOW: begin
                        n_display = {r_dest | r_entry[7:4], r_entry[7:4]};
                    end
                    erq_pkg::KIND_CLEAR: begin
                        n_active = '0;
                    end
                    default: begin
                    end
                endcase
                n_res.not_empty    = (n_count != '0);
                n_res.display_bits = n_display;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= erq_pkg::ST_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_active  <= '0;
            r_display <= '0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_rd_vld  <= n_rd_vld;
            r_active  <= n_active;
            r_display <= n_display;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_entry  <= n_entry;
        r_source <= n_source;
        r_hit    <= n_hit;
        r_dest   <= n_dest;
        r_pop    <= n_pop;
        r_res    <= n_res;
    end

endmodule

`default_nettype wire

// ----- src/exit_request_queue.sv -----
// Top level of the exit request queue: stream ports, result output register
// and checks. Depends on erq_pkg and erq_ctrl.
//
//  channel   direction  tdata (lsb up)                          tuser
//  s_axis    in         entry[7:0], source[11:8], zero pad      kind[2:0]
//  m_axis    out        accepted[0], popped[8:1], is_queued[9], -
//                       not_empty[10], display_bits[18:11], pad
//
// One transaction at a time; the queue lives in a ring in one RAM port pair.
// Push, clear and unused kinds read no entry, a pop reads the head of a
// non-empty queue, and a query or a show reads every queued entry; the scan
// reads one entry a cycle.
// Reset is synchronous and empties the queue at once; no clearing pass.
// A waiting result sits in the output register while the next transaction
// is taken; a stall on m_axis holds the sequencer once that register is full.
`default_nettype none

module exit_request_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // entry[7:0], source[11:8], zero[15:12]
    input  wire logic [2:0]  s_axis_tuser,   // kind[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata    // accepted, popped, is_queued, not_empty,
                                             // display_bits, zero[23:19]
);

    logic                 w_res_valid;
    logic                 w_res_ready;
    erq_pkg::t_erq_result w_res;
    erq_pkg::t_erq_status w_stat;

    logic                 r_out_vld, n_out_vld;
    erq_pkg::t_erq_result r_out, n_out;

    erq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_kind     (s_axis_tuser),
        .i_entry    (s_axis_tdata[7:0]),
        .i_source   (s_axis_tdata[11:8]),
        .o_res_valid(w_res_valid),
        .i_res_ready(w_res_ready),
        .o_res      (w_res),
        .o_status   (w_stat)
    );

    // Output register loads when empty or being drained.
    assign w_res_ready = !r_out_vld || m_axis_tready;

    always_comb begin
        n_out_vld = r_out_vld;
        n_out     = r_out;
        if (m_axis_tready) begin
            n_out_vld = 1'b0;
        end
        if (w_res_valid && w_res_ready) begin
            n_out_vld = 1'b1;
            n_out     = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // Pack the result transaction.
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'b0, r_out.display_bits, r_out.not_empty, r_out.is_queued,
                            r_out.popped, r_out.accepted};

    // The sequencer works on one transaction at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a transaction is in flight");

    // The ring never holds more entries than it has slots.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.count <= erq_pkg::t_cnt'(erq_pkg::QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    // The reported not-empty flag agrees with the committed fill count.
    a_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> (w_res.not_empty == (w_stat.count != '0)))
        else $error("not_empty disagrees with fill count");

    // A handed-over result shows up on the output.
    a_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid && w_res_ready |=> m_axis_tvalid)
        else $error("result lost between sequencer and output register");

endmodule

`default_nettype wire
